FILE: hdl/rbsi_pkg.sv
// Package for the ray and box slab intersection block.
// It holds the shared widths, the saturation limits and the structs passed between stages.
// It depends on nothing else.
package rbsi_pkg;

   // Field widths. Data is signed Q16.16.
   localparam int DataW = 32;
   localparam int QFrac = 16;
   // A plane minus the origin needs one more bit than the data.
   localparam int NumW  = DataW + 1;
   // Width of the shifted dividend, and the number of quotient bits.
   localparam int DivW  = NumW + QFrac;
   // Divider depth: a magnitude stage, one stage per quotient bit, and a sign stage.
   localparam int DivLat = DivW + 2;

   // Saturation limits of the signed 32-bit result.
   localparam logic signed [DataW-1:0] S32Max = {1'b0, {(DataW-1){1'b1}}};
   localparam logic signed [DataW-1:0] S32Min = {1'b1, {(DataW-1){1'b0}}};
   // The same limits as unsigned quotient magnitudes.
   localparam logic [DivW-1:0] QPosLim = {{(DivW-DataW+1){1'b0}}, {(DataW-1){1'b1}}};
   localparam logic [DivW-1:0] QNegLim = {{(DivW-DataW){1'b0}}, 1'b1, {(DataW-1){1'b0}}};

   // Normal components.
   localparam logic signed [1:0] NrmPos  = 2'sb01;
   localparam logic signed [1:0] NrmNeg  = 2'sb11;
   localparam logic signed [1:0] NrmZero = 2'sb00;

   // Ray origin and direction, carried alongside the division.
   typedef struct packed {
      logic signed [DataW-1:0] ox;
      logic signed [DataW-1:0] oy;
      logic signed [DataW-1:0] dx;
      logic signed [DataW-1:0] dy;
   } side_type;

   // Per-word control passed from the slab test to the contact stages.
   typedef struct packed {
      logic              valid;
      logic              hit;
      logic signed [1:0] nrm_x;
      logic signed [1:0] nrm_y;
   } slab_ctl_type;

endpackage

FILE: hdl/rbsi_divider.sv
// Pipelined restoring divider producing a saturated signed Q16.16 quotient.
// It retires one quotient bit per stage and accepts a new word every enabled cycle.
// It depends on rbsi_pkg.
module rbsi_divider (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [rbsi_pkg::NumW-1:0]  num,
   input  logic signed [rbsi_pkg::DataW-1:0] den,
   output logic signed [rbsi_pkg::DataW-1:0] quot,
   output logic                             undef
);
   import rbsi_pkg::*;

   typedef struct packed {
      logic neg;
      logic num_neg;
      logic num_zero;
      logic den_zero;
   } div_flag_type;

   logic [DataW-1:0]  rem_ff  [DivW+1];
   logic [DivW-1:0]   dq_ff   [DivW+1];
   logic [DataW-1:0]  dm_ff   [DivW+1];
   div_flag_type      flag_ff [DivW+1];

   logic [NumW-1:0]   num_mag_in;
   logic [DataW-1:0]  den_mag_in;
   div_flag_type      flag_in;

   logic [DivW-1:0]         q_mag;
   div_flag_type            q_flag;
   logic signed [DataW-1:0] quot_in;
   logic                    undef_in;
   logic signed [DataW-1:0] quot_ff;
   logic                    undef_ff;

   // Take magnitudes and record the signs and zero cases.
   always_comb begin
      num_mag_in       = num[NumW-1] ? NumW'(-num) : NumW'(num);
      den_mag_in       = den[DataW-1] ? DataW'(-den) : DataW'(den);
      flag_in.num_neg  = num[NumW-1];
      flag_in.neg      = num[NumW-1] ^ den[DataW-1];
      flag_in.num_zero = (num == '0);
      flag_in.den_zero = (den == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= '0;
         dq_ff[0]   <= {num_mag_in, {QFrac{1'b0}}};
         dm_ff[0]   <= den_mag_in;
         flag_ff[0] <= flag_in;
      end
   end

   // One quotient bit per stage: dividend bits shift out, quotient bits shift in.
   for (genvar g = 0; g < DivW; g++) begin : g_step
      logic [DataW:0]   trial;
      logic             fits;
      logic [DataW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[g], dq_ff[g][DivW-1]};
         fits   = (trial >= {1'b0, dm_ff[g]});
         rem_in = fits ? DataW'(trial - {1'b0, dm_ff[g]}) : trial[DataW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g+1]  <= rem_in;
            dq_ff[g+1]   <= {dq_ff[g][DivW-2:0], fits};
            dm_ff[g+1]   <= dm_ff[g];
            flag_ff[g+1] <= flag_ff[g];
         end
      end
   end

   // Apply the sign, saturate, and handle a zero divisor.
   always_comb begin
      q_mag    = dq_ff[DivW];
      q_flag   = flag_ff[DivW];
      undef_in = 1'b0;
      if (q_flag.den_zero) begin
         undef_in = q_flag.num_zero;
         quot_in  = q_flag.num_neg ? S32Min : S32Max;
      end else if (!q_flag.neg) begin
         quot_in = (q_mag > QPosLim) ? S32Max : $signed(q_mag[DataW-1:0]);
      end else begin
         quot_in = (q_mag > QNegLim) ? S32Min : $signed(DataW'(-q_mag[DataW-1:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff  <= quot_in;
         undef_ff <= undef_in;
      end
   end

   assign quot  = quot_ff;
   assign undef = undef_ff;

endmodule

FILE: hdl/rbsi_resolve.sv
// Slab test: orders the per-axis times, rejects misses and picks entry time and normal.
// Two register stages.
// It depends on rbsi_pkg.
module rbsi_resolve (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic                             in_undef,
   input  rbsi_pkg::side_type               side_in,
   input  logic signed [rbsi_pkg::DataW-1:0] t_min_x,
   input  logic signed [rbsi_pkg::DataW-1:0] t_max_x,
   input  logic signed [rbsi_pkg::DataW-1:0] t_min_y,
   input  logic signed [rbsi_pkg::DataW-1:0] t_max_y,
   output rbsi_pkg::side_type               side_out,
   output rbsi_pkg::slab_ctl_type           ctl_out,
   output logic signed [rbsi_pkg::DataW-1:0] tn_out
);
   import rbsi_pkg::*;

   logic                    a_valid_ff;
   logic                    a_ok_ff;
   side_type                a_side_ff;
   logic signed [DataW-1:0] a_nx_ff, a_fx_ff, a_ny_ff, a_fy_ff;

   slab_ctl_type            b_ctl_ff, b_ctl_in;
   side_type                b_side_ff;
   logic signed [DataW-1:0] b_tn_ff, b_tn_in;
   logic signed [DataW-1:0] tf;

   // Order each axis pair so near is not above far.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ok_ff   <= !in_undef;
         a_side_ff <= side_in;
         a_nx_ff   <= (t_min_x > t_max_x) ? t_max_x : t_min_x;
         a_fx_ff   <= (t_min_x > t_max_x) ? t_min_x : t_max_x;
         a_ny_ff   <= (t_min_y > t_max_y) ? t_max_y : t_min_y;
         a_fy_ff   <= (t_min_y > t_max_y) ? t_min_y : t_max_y;
      end
   end

   // Overlap and behind-the-ray checks, entry time and normal choice.
   always_comb begin
      b_tn_in        = (a_nx_ff > a_ny_ff) ? a_nx_ff : a_ny_ff;
      tf             = (a_fx_ff < a_fy_ff) ? a_fx_ff : a_fy_ff;
      b_ctl_in.valid = a_valid_ff;
      b_ctl_in.hit   = a_ok_ff && !(a_nx_ff > a_fy_ff) && !(a_ny_ff > a_fx_ff)
                       && !tf[DataW-1];
      b_ctl_in.nrm_x = NrmZero;
      b_ctl_in.nrm_y = NrmZero;
      if (a_nx_ff > a_ny_ff) begin
         b_ctl_in.nrm_x = a_side_ff.dx[DataW-1] ? NrmPos : NrmNeg;
      end else begin
         b_ctl_in.nrm_y = a_side_ff.dy[DataW-1] ? NrmPos : NrmNeg;
      end
   end

   // Only the valid bit is reset; the rest of the word loads on every advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         b_ctl_ff.valid <= b_ctl_in.valid;
      end
      if (en) begin
         b_ctl_ff.hit   <= b_ctl_in.hit;
         b_ctl_ff.nrm_x <= b_ctl_in.nrm_x;
         b_ctl_ff.nrm_y <= b_ctl_in.nrm_y;
         b_tn_ff        <= b_tn_in;
         b_side_ff      <= a_side_ff;
      end
   end

   assign side_out = b_side_ff;
   assign ctl_out  = b_ctl_ff;
   assign tn_out   = b_tn_ff;

endmodule

FILE: hdl/rbsi_contact.sv
// Contact point: multiplies entry time by direction, then floors, adds origin and saturates.
// Two register stages; the second is the output register.
// It depends on rbsi_pkg.
module rbsi_contact (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  rbsi_pkg::slab_ctl_type            ctl_in,
   input  rbsi_pkg::side_type                side_in,
   input  logic signed [rbsi_pkg::DataW-1:0]  tn_in,
   output logic                              out_valid,
   output logic                              out_hit,
   output logic signed [rbsi_pkg::DataW-1:0] out_entry_time,
   output logic signed [rbsi_pkg::DataW-1:0] out_contact_x,
   output logic signed [rbsi_pkg::DataW-1:0] out_contact_y,
   output logic signed [1:0]                 out_normal_x,
   output logic signed [1:0]                 out_normal_y
);
   import rbsi_pkg::*;

   localparam int ProdW = 2 * DataW;
   localparam int SumW  = ProdW - QFrac + 1;

   slab_ctl_type              c_ctl_ff;
   logic signed [ProdW-1:0]   c_px_ff, c_py_ff;
   logic signed [DataW-1:0]   c_ox_ff, c_oy_ff, c_tn_ff;

   logic signed [SumW-1:0]    sum_x, sum_y;
   logic signed [DataW-1:0]   cx_in, cy_in;

   logic                      valid_ff;
   logic                      hit_ff;
   logic signed [DataW-1:0]   entry_ff, cx_ff, cy_ff;
   logic signed [1:0]         nx_ff, ny_ff;

   function automatic logic signed [DataW-1:0] sat_sum(input logic signed [SumW-1:0] v);
      logic signed [SumW-1:0] hi;
      logic signed [SumW-1:0] lo;
      hi = SumW'(S32Max);
      lo = SumW'(S32Min);
      if (v > hi) return S32Max;
      if (v < lo) return S32Min;
      return v[DataW-1:0];
   endfunction

   // Products of entry time and direction; only the valid bit is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ctl_ff.valid <= 1'b0;
      end else if (en) begin
         c_ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         c_ctl_ff.hit   <= ctl_in.hit;
         c_ctl_ff.nrm_x <= ctl_in.nrm_x;
         c_ctl_ff.nrm_y <= ctl_in.nrm_y;
         c_px_ff        <= ProdW'(tn_in) * ProdW'(side_in.dx);
         c_py_ff        <= ProdW'(tn_in) * ProdW'(side_in.dy);
         c_ox_ff        <= side_in.ox;
         c_oy_ff        <= side_in.oy;
         c_tn_ff        <= tn_in;
      end
   end

   // The arithmetic shift rounds toward minus infinity.
   always_comb begin
      sum_x = SumW'(c_px_ff >>> QFrac) + SumW'(c_ox_ff);
      sum_y = SumW'(c_py_ff >>> QFrac) + SumW'(c_oy_ff);
      cx_in = sat_sum(sum_x);
      cy_in = sat_sum(sum_y);
   end

   // Output register; a miss clears every field.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= c_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= c_ctl_ff.hit;
         entry_ff <= c_ctl_ff.hit ? c_tn_ff : '0;
         cx_ff    <= c_ctl_ff.hit ? cx_in : '0;
         cy_ff    <= c_ctl_ff.hit ? cy_in : '0;
         nx_ff    <= c_ctl_ff.hit ? c_ctl_ff.nrm_x : NrmZero;
         ny_ff    <= c_ctl_ff.hit ? c_ctl_ff.nrm_y : NrmZero;
      end
   end

   assign out_valid      = valid_ff;
   assign out_hit        = hit_ff;
   assign out_entry_time = entry_ff;
   assign out_contact_x  = cx_ff;
   assign out_contact_y  = cy_ff;
   assign out_normal_x   = nx_ff;
   assign out_normal_y   = ny_ff;

endmodule

FILE: hdl/ray_box_slab_intersect.sv
// Top level of the 2D ray against axis-aligned box intersection block.
// It instantiates rbsi_divider, rbsi_resolve and rbsi_contact, and uses rbsi_pkg.
//
// Usage:
// The req_ channel carries one word per test: ray origin, ray direction and the
// box minimum and maximum corners, all signed Q16.16. The rsp_ channel returns
// exactly one word per request, in order: hit flag, entry time, contact point
// and an axis-aligned unit normal. A miss returns all fields zero.
// Both channels use a valid and ready handshake.
// The path from the accepting edge to the edge that raises rsp_valid runs
// through 56 register stages: one input stage forming the plane distances,
// 51 stages in the four parallel dividers (magnitude, one per quotient bit, sign),
// two slab-test stages and two contact stages.
// Throughput is one word per cycle unless the receiver stalls; the divider pipeline depth sets the latency.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Synchronous reset empties the pipeline; no response is valid after reset.
module ray_box_slab_intersect (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_origin_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_origin_y,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_dir_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_dir_y,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_box_min_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_box_min_y,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_box_max_x,
   input  logic signed [rbsi_pkg::DataW-1:0]  req_box_max_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit,
   output logic signed [rbsi_pkg::DataW-1:0] rsp_entry_time,
   output logic signed [rbsi_pkg::DataW-1:0] rsp_contact_x,
   output logic signed [rbsi_pkg::DataW-1:0] rsp_contact_y,
   output logic signed [1:0]                 rsp_normal_x,
   output logic signed [1:0]                 rsp_normal_y
);
   import rbsi_pkg::*;

   logic                   adv;
   logic                   vld_ff  [DivLat+1];
   side_type               side_ff [DivLat+1];
   side_type               side_in;
   logic signed [NumW-1:0] num_ff [4];
   logic signed [NumW-1:0] num_in [4];

   logic signed [DataW-1:0] quot [4];
   logic                    undef [4];

   side_type                rs_side;
   slab_ctl_type            rs_ctl;
   logic signed [DataW-1:0] rs_tn;

   // The pipeline moves whenever the output register is free or being read.
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Input stage: distances from the origin to the four box planes.
   always_comb begin
      side_in.ox = req_origin_x;
      side_in.oy = req_origin_y;
      side_in.dx = req_dir_x;
      side_in.dy = req_dir_y;
      num_in[0]  = NumW'(req_box_min_x) - NumW'(req_origin_x);
      num_in[1]  = NumW'(req_box_max_x) - NumW'(req_origin_x);
      num_in[2]  = NumW'(req_box_min_y) - NumW'(req_origin_y);
      num_in[3]  = NumW'(req_box_max_y) - NumW'(req_origin_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         num_ff     <= num_in;
      end
   end

   // Valid bits and ray data travel beside the dividers.
   for (genvar k = 0; k < DivLat; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // Four plane quotients in parallel.
   for (genvar d = 0; d < 4; d++) begin : g_div
      rbsi_divider u_div (
         .clock (clock),
         .en    (adv),
         .num   (num_ff[d]),
         .den   ((d < 2) ? side_ff[0].dx : side_ff[0].dy),
         .quot  (quot[d]),
         .undef (undef[d])
      );
   end

   rbsi_resolve u_resolve (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (vld_ff[DivLat]),
      .in_undef (undef[0] || undef[1] || undef[2] || undef[3]),
      .side_in  (side_ff[DivLat]),
      .t_min_x  (quot[0]),
      .t_max_x  (quot[1]),
      .t_min_y  (quot[2]),
      .t_max_y  (quot[3]),
      .side_out (rs_side),
      .ctl_out  (rs_ctl),
      .tn_out   (rs_tn)
   );

   rbsi_contact u_contact (
      .clock          (clock),
      .reset          (reset),
      .en             (adv),
      .ctl_in         (rs_ctl),
      .side_in        (rs_side),
      .tn_in          (rs_tn),
      .out_valid      (rsp_valid),
      .out_hit        (rsp_hit),
      .out_entry_time (rsp_entry_time),
      .out_contact_x  (rsp_contact_x),
      .out_contact_y  (rsp_contact_y),
      .out_normal_x   (rsp_normal_x),
      .out_normal_y   (rsp_normal_y)
   );

endmodule

FILE: hdl/rbsi_checker.sv
// Port-level checks for the ray and box slab intersection block, and the bind that attaches them.
// It depends on rbsi_pkg and the ports of ray_box_slab_intersect.
module rbsi_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_hit,
   input logic signed [rbsi_pkg::DataW-1:0] rsp_entry_time,
   input logic signed [rbsi_pkg::DataW-1:0] rsp_contact_x,
   input logic signed [rbsi_pkg::DataW-1:0] rsp_contact_y,
   input logic signed [1:0]                 rsp_normal_x,
   input logic signed [1:0]                 rsp_normal_y
);
   import rbsi_pkg::*;

   // A waiting response holds its valid, hit flag, entry time and contact x until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_entry_time) && $stable(rsp_contact_x))
      else $error("response word changed while stalled");

   // A miss carries all-zero fields.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_entry_time == '0 && rsp_contact_x == '0
         && rsp_contact_y == '0 && rsp_normal_x == NrmZero && rsp_normal_y == NrmZero)
      else $error("miss with nonzero fields");

   // A hit has exactly one nonzero normal component.
   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_normal_x == NrmZero) != (rsp_normal_y == NrmZero))
      else $error("hit normal is not axis aligned");

   // Request side stalls exactly when a response waits unread.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow the output stall");

   // Reset leaves no response valid.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_entry_time (rsp_entry_time),
   .rsp_contact_x  (rsp_contact_x),
   .rsp_contact_y  (rsp_contact_y),
   .rsp_normal_x   (rsp_normal_x),
   .rsp_normal_y   (rsp_normal_y)
);
